### src/lrfc_pkg.sv
// shared types, constants and functions of the log record frame checker
package lrfc_pkg;

   localparam int BODY_COUNT_WIDTH_DEF = 17;
   localparam int OFFSET_WIDTH_DEF = 48;
   localparam int CSR_DATA_WIDTH = 17;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] CSR_MAX_BODY = 2'd0;
   localparam logic [1:0] CSR_MAX_TYPE = 2'd1;
   localparam logic [1:0] CSR_MAX_STORE = 2'd2;

   localparam logic [16:0] MAX_BODY_RESET = 17'd65536;
   localparam logic [7:0] MAX_TAG_RESET = 8'hFF;

   typedef enum logic [3:0] {
      ST_VALID = 4'd0,
      ST_CLEAN_END = 4'd1,
      ST_TORN_LEN = 4'd2,
      ST_OVER_CAP = 4'd3,
      ST_TORN_BODY = 4'd4,
      ST_TORN_CRC = 4'd5,
      ST_CRC_BAD = 4'd6,
      ST_MALFORMED = 4'd7,
      ST_BAD_TYPE = 4'd8,
      ST_BAD_STORE = 4'd9
   } status_type;

   typedef enum logic [3:0] {
      PH_LEN = 4'd0,
      PH_SEQ = 4'd1,
      PH_PREV = 4'd2,
      PH_TXN = 4'd3,
      PH_TYPE = 4'd4,
      PH_STORE = 4'd5,
      PH_PAGE = 4'd6,
      PH_LENA = 4'd7,
      PH_BLOBA = 4'd8,
      PH_LENB = 4'd9,
      PH_BLOBB = 4'd10,
      PH_TRAIL = 4'd11,
      PH_CRC = 4'd12
   } phase_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [3:0] field_size(input phase_type ph);
      logic [3:0] s;
      case (ph)
         PH_SEQ, PH_PREV, PH_TXN: s = 4'd8;
         PH_TYPE, PH_STORE: s = 4'd1;
         PH_LEN, PH_PAGE, PH_LENA, PH_LENB, PH_CRC: s = 4'd4;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

endpackage

### src/lrfc_req_if.sv
// request channel carrying stream words
interface lrfc_req_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   modport source (output valid, kind, data_byte, input ready);
   modport sink (input valid, kind, data_byte, output ready);
endinterface

### src/lrfc_rsp_if.sv
// response channel carrying record reports
interface lrfc_rsp_if #(
   parameter int OFFSET_WIDTH = lrfc_pkg::OFFSET_WIDTH_DEF
);
   logic valid;
   logic ready;
   logic [3:0] status;
   logic [63:0] seq_number;
   logic [63:0] previous_seq;
   logic [63:0] transaction_id;
   logic [7:0] record_type;
   logic [7:0] store_kind;
   logic signed [31:0] page_number;
   logic [16:0] before_len;
   logic [16:0] after_len;
   logic [OFFSET_WIDTH-1:0] good_end_offset;
   modport source (output valid, status, seq_number, previous_seq, transaction_id,
      record_type, store_kind, page_number, before_len, after_len, good_end_offset,
      input ready);
   modport sink (input valid, status, seq_number, previous_seq, transaction_id,
      record_type, store_kind, page_number, before_len, after_len, good_end_offset,
      output ready);
endinterface

### src/log_record_frame_checker.sv
// log record frame checker: length-prefixed record parse with crc-32 check
// the report word is registered and appears in the cycle after the last crc byte (or end of log)
// throughput: one stream word per cycle; the output register holds one report and
//   input stalls while a report waits and the output side is not ready
// reset: synchronous, active high; clears the scan state and sets the
//   registers to a body cap of 65536 and widest tag limits; no memory, no clearing pass
module log_record_frame_checker #(
   parameter int BODY_COUNT_WIDTH = lrfc_pkg::BODY_COUNT_WIDTH_DEF,
   parameter int OFFSET_WIDTH = lrfc_pkg::OFFSET_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   lrfc_req_if.sink req,
   lrfc_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic [lrfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [lrfc_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);

   localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};
   localparam logic [31:0] CNT_CAP = 32'((64'd1 << BODY_COUNT_WIDTH) - 64'd1);

   logic [16:0] max_body_ff;
   logic [7:0] max_type_ff, max_store_ff;

   lrfc_pkg::phase_type phase_ff, phase_in;
   logic [3:0] fcount_ff, fcount_in;
   logic [BODY_COUNT_WIDTH-1:0] body_left_ff, body_left_in;
   logic [31:0] crc_ff, crc_in;
   logic [63:0] shift_ff, shift_in;
   logic [63:0] hw0_ff, hw0_in, hw1_ff, hw1_in, hw2_ff, hw2_in;
   logic [7:0] tag0_ff, tag0_in, tag1_ff, tag1_in;
   logic [31:0] page_ff, page_in;
   logic [31:0] blen0_ff, blen0_in, blen1_ff, blen1_in;
   logic [31:0] blob_left_ff, blob_left_in;
   logic malformed_ff, malformed_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in, good_ff, good_in;
   logic stopped_ff, stopped_in;

   logic out_valid_ff;
   lrfc_pkg::status_type out_status_ff, status_c;
   logic [63:0] o_hw0_ff, o_hw1_ff, o_hw2_ff;
   logic [7:0] o_tag0_ff, o_tag1_ff;
   logic [31:0] o_page_ff;
   logic [16:0] o_blen0_ff, o_blen1_ff;
   logic [OFFSET_WIDTH-1:0] o_good_ff;

   logic accept, emit, valid_rec;
   logic [63:0] asm_c;
   logic [3:0] cnt_c;
   logic [31:0] v32;
   logic [31:0] cap_c;
   logic [31:0] crc_next;

   assign accept = req.valid & req.ready;
   assign req.ready = !out_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= lrfc_pkg::MAX_BODY_RESET;
         max_type_ff <= lrfc_pkg::MAX_TAG_RESET;
         max_store_ff <= lrfc_pkg::MAX_TAG_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lrfc_pkg::CSR_MAX_BODY: max_body_ff <= csr_write_data;
            lrfc_pkg::CSR_MAX_TYPE: max_type_ff <= csr_write_data[7:0];
            lrfc_pkg::CSR_MAX_STORE: max_store_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      fcount_in = fcount_ff;
      body_left_in = body_left_ff;
      crc_in = crc_ff;
      shift_in = shift_ff;
      hw0_in = hw0_ff;
      hw1_in = hw1_ff;
      hw2_in = hw2_ff;
      tag0_in = tag0_ff;
      tag1_in = tag1_ff;
      page_in = page_ff;
      blen0_in = blen0_ff;
      blen1_in = blen1_ff;
      blob_left_in = blob_left_ff;
      malformed_in = malformed_ff;
      offset_in = offset_ff;
      good_in = good_ff;
      stopped_in = stopped_ff;
      emit = 1'b0;
      valid_rec = 1'b0;
      status_c = lrfc_pkg::ST_VALID;
      asm_c = shift_ff | ({56'd0, req.data_byte} << {fcount_ff[2:0], 3'b000});
      cnt_c = fcount_ff + 4'd1;
      v32 = asm_c[31:0];
      cap_c = ({15'd0, max_body_ff} < CNT_CAP) ? {15'd0, max_body_ff} : CNT_CAP;
      crc_next = lrfc_pkg::crc_byte(crc_ff, req.data_byte);

      if (accept) begin
         if (req.kind == lrfc_pkg::KIND_RESTART) begin
            phase_in = lrfc_pkg::PH_LEN;
            fcount_in = '0;
            body_left_in = '0;
            crc_in = lrfc_pkg::CRC_ONES;
            shift_in = '0;
            hw0_in = '0;
            hw1_in = '0;
            hw2_in = '0;
            tag0_in = '0;
            tag1_in = '0;
            page_in = '0;
            blen0_in = '0;
            blen1_in = '0;
            blob_left_in = '0;
            malformed_in = 1'b0;
            offset_in = '0;
            good_in = '0;
            stopped_in = 1'b0;
         end else if (stopped_ff || req.kind == lrfc_pkg::KIND_UNUSED) begin
         end else if (req.kind == lrfc_pkg::KIND_END) begin
            emit = 1'b1;
            stopped_in = 1'b1;
            if (phase_ff == lrfc_pkg::PH_LEN) begin
               status_c = (fcount_ff != 4'd0) ? lrfc_pkg::ST_TORN_LEN : lrfc_pkg::ST_CLEAN_END;
            end else if (phase_ff == lrfc_pkg::PH_CRC) begin
               status_c = lrfc_pkg::ST_TORN_CRC;
            end else begin
               status_c = lrfc_pkg::ST_TORN_BODY;
            end
         end else begin
            if (offset_ff != OFF_MAX) offset_in = offset_ff + 1'b1;
            if (phase_ff == lrfc_pkg::PH_LEN) begin
               shift_in = asm_c;
               fcount_in = cnt_c;
               if (cnt_c == 4'd4) begin
                  if (v32 > cap_c) begin
                     emit = 1'b1;
                     stopped_in = 1'b1;
                     status_c = lrfc_pkg::ST_OVER_CAP;
                  end else begin
                     body_left_in = v32[BODY_COUNT_WIDTH-1:0];
                     crc_in = lrfc_pkg::CRC_ONES;
                     fcount_in = '0;
                     shift_in = '0;
                     if (v32 == 32'd0) begin
                        malformed_in = 1'b1;
                        phase_in = lrfc_pkg::PH_CRC;
                     end else begin
                        malformed_in = 1'b0;
                        phase_in = lrfc_pkg::PH_SEQ;
                     end
                  end
               end
            end else if (phase_ff != lrfc_pkg::PH_CRC) begin
               crc_in = crc_next;
               body_left_in = body_left_ff - 1'b1;
               if (phase_ff == lrfc_pkg::PH_BLOBA || phase_ff == lrfc_pkg::PH_BLOBB) begin
                  blob_left_in = blob_left_ff - 32'd1;
                  if (blob_left_ff == 32'd1) begin
                     phase_in = (phase_ff == lrfc_pkg::PH_BLOBA)
                        ? lrfc_pkg::PH_LENB : lrfc_pkg::PH_TRAIL;
                  end
               end else if (phase_ff != lrfc_pkg::PH_TRAIL) begin
                  shift_in = asm_c;
                  fcount_in = cnt_c;
                  if (cnt_c == lrfc_pkg::field_size(phase_ff)) begin
                     fcount_in = '0;
                     shift_in = '0;
                     case (phase_ff)
                        lrfc_pkg::PH_SEQ: begin
                           hw0_in = asm_c;
                           phase_in = lrfc_pkg::PH_PREV;
                        end
                        lrfc_pkg::PH_PREV: begin
                           hw1_in = asm_c;
                           phase_in = lrfc_pkg::PH_TXN;
                        end
                        lrfc_pkg::PH_TXN: begin
                           hw2_in = asm_c;
                           phase_in = lrfc_pkg::PH_TYPE;
                        end
                        lrfc_pkg::PH_TYPE: begin
                           tag0_in = asm_c[7:0];
                           phase_in = lrfc_pkg::PH_STORE;
                        end
                        lrfc_pkg::PH_STORE: begin
                           tag1_in = asm_c[7:0];
                           phase_in = lrfc_pkg::PH_PAGE;
                        end
                        lrfc_pkg::PH_PAGE: begin
                           page_in = v32;
                           phase_in = lrfc_pkg::PH_LENA;
                        end
                        lrfc_pkg::PH_LENA: begin
                           blen0_in = v32;
                           blob_left_in = v32;
                           phase_in = (v32 != 32'd0) ? lrfc_pkg::PH_BLOBA : lrfc_pkg::PH_LENB;
                        end
                        default: begin
                           blen1_in = v32;
                           blob_left_in = v32;
                           phase_in = (v32 != 32'd0) ? lrfc_pkg::PH_BLOBB : lrfc_pkg::PH_TRAIL;
                        end
                     endcase
                  end
               end
               if (body_left_ff == {{(BODY_COUNT_WIDTH-1){1'b0}}, 1'b1}) begin
                  malformed_in = (phase_in != lrfc_pkg::PH_TRAIL);
                  phase_in = lrfc_pkg::PH_CRC;
                  fcount_in = '0;
                  shift_in = '0;
               end
            end else begin
               shift_in = asm_c;
               fcount_in = cnt_c;
               if (cnt_c == 4'd4) begin
                  emit = 1'b1;
                  if (v32 != (crc_ff ^ lrfc_pkg::CRC_ONES)) begin
                     status_c = lrfc_pkg::ST_CRC_BAD;
                  end else if (malformed_ff) begin
                     status_c = lrfc_pkg::ST_MALFORMED;
                  end else if (tag0_ff > max_type_ff) begin
                     status_c = lrfc_pkg::ST_BAD_TYPE;
                  end else if (tag1_ff > max_store_ff) begin
                     status_c = lrfc_pkg::ST_BAD_STORE;
                  end else begin
                     status_c = lrfc_pkg::ST_VALID;
                  end
                  if (status_c != lrfc_pkg::ST_VALID) begin
                     stopped_in = 1'b1;
                  end else begin
                     valid_rec = 1'b1;
                     good_in = offset_in;
                     phase_in = lrfc_pkg::PH_LEN;
                     fcount_in = '0;
                     shift_in = '0;
                     crc_in = lrfc_pkg::CRC_ONES;
                     malformed_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lrfc_pkg::PH_LEN;
         fcount_ff <= '0;
         body_left_ff <= '0;
         crc_ff <= lrfc_pkg::CRC_ONES;
         shift_ff <= '0;
         hw0_ff <= '0;
         hw1_ff <= '0;
         hw2_ff <= '0;
         tag0_ff <= '0;
         tag1_ff <= '0;
         page_ff <= '0;
         blen0_ff <= '0;
         blen1_ff <= '0;
         blob_left_ff <= '0;
         malformed_ff <= 1'b0;
         offset_ff <= '0;
         good_ff <= '0;
         stopped_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         fcount_ff <= fcount_in;
         body_left_ff <= body_left_in;
         crc_ff <= crc_in;
         shift_ff <= shift_in;
         hw0_ff <= hw0_in;
         hw1_ff <= hw1_in;
         hw2_ff <= hw2_in;
         tag0_ff <= tag0_in;
         tag1_ff <= tag1_in;
         page_ff <= page_in;
         blen0_ff <= blen0_in;
         blen1_ff <= blen1_in;
         blob_left_ff <= blob_left_in;
         malformed_ff <= malformed_in;
         offset_ff <= offset_in;
         good_ff <= good_in;
         stopped_ff <= stopped_in;
         if (emit) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   // report word, zero header fields on a stop
   always_ff @(posedge clock) begin
      if (emit) begin
         out_status_ff <= status_c;
         o_hw0_ff <= valid_rec ? hw0_ff : '0;
         o_hw1_ff <= valid_rec ? hw1_ff : '0;
         o_hw2_ff <= valid_rec ? hw2_ff : '0;
         o_tag0_ff <= valid_rec ? tag0_ff : '0;
         o_tag1_ff <= valid_rec ? tag1_ff : '0;
         o_page_ff <= valid_rec ? page_ff : '0;
         o_blen0_ff <= valid_rec ? blen0_ff[16:0] : '0;
         o_blen1_ff <= valid_rec ? blen1_ff[16:0] : '0;
         o_good_ff <= good_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.status = out_status_ff;
   assign rsp.seq_number = o_hw0_ff;
   assign rsp.previous_seq = o_hw1_ff;
   assign rsp.transaction_id = o_hw2_ff;
   assign rsp.record_type = o_tag0_ff;
   assign rsp.store_kind = o_tag1_ff;
   assign rsp.page_number = o_page_ff;
   assign rsp.before_len = o_blen0_ff;
   assign rsp.after_len = o_blen1_ff;
   assign rsp.good_end_offset = o_good_ff;

endmodule

### src/lrfc_checker.sv
// port-level assertions for the log record frame checker and their bind
module lrfc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [3:0] rsp_status,
   input logic [63:0] rsp_seq_number,
   input logic [7:0] rsp_record_type
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("report word dropped while stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= lrfc_pkg::ST_BAD_STORE)
      else $error("status out of range");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lrfc_pkg::ST_VALID
         |-> rsp_seq_number == 64'd0 && rsp_record_type == 8'd0)
      else $error("stop report carries header");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("report right after reset");

endmodule

bind log_record_frame_checker lrfc_checker u_lrfc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_status(rsp.status),
   .rsp_seq_number(rsp.seq_number),
   .rsp_record_type(rsp.record_type)
);
